// File: hdl/bounded_ordered_list_macros.svh
// ----------------------------------------------------------------------------
// bounded_ordered_list_macros
// Assertion macros used by the ordered list controller (bol_ctrl).
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_MACROS_SVH
`define BOUNDED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define BOL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define BOL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg
// Request kinds, status codes and cell command type for the ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT    = 2'd0,
		KIND_REMOVE    = 2'd1,
		KIND_OVERWRITE = 2'd2,
		KIND_READ      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell; each cell decodes its own move from it.
	typedef struct packed {
		logic ins;   // insert accepted: shift up from position, load at position
		logic rem;   // remove accepted: shift down from position
		logic wr;    // overwrite accepted: load at position
	} cell_cmd_t;

	localparam int CAP_RESET = 16;

endpackage

// File: hdl/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell
// One list slot: holds an entry, loads a new word or takes its neighbor's.
// ----------------------------------------------------------------------------
module bol_cell import bol_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int PW         = 4,
	parameter int CW         = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [PW-1:0]         pos,
	input  logic [CW-1:0]         cnt,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [CW-1:0]         pos_x;
	logic [DATA_WIDTH-1:0] entry_nx;

	assign pos_x = CW'(pos);

	always_comb begin
		entry_nx = entry_q;
		if ((cmd.ins || cmd.wr) && IDX == pos_x) begin
			entry_nx = value;
		end else if (cmd.ins && IDX > pos_x && IDX <= cnt) begin
			entry_nx = left_data;
		end else if (cmd.rem && IDX >= pos_x && IDX < cnt - CW'(1)) begin
			// cnt is at least one here: a remove is only accepted below count
			entry_nx = right_data;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nx;
	end

	assign data = entry_q;

endmodule

// File: hdl/bol_ctrl.sv
// ----------------------------------------------------------------------------
// bol_ctrl
// Count and capacity registers, request checks, cell command and result beat.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_macros.svh"

module bol_ctrl import bol_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PW         = 4,
	parameter int CW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            kind,
	input  logic [PW-1:0]         position,
	input  logic                  cfg_valid,
	input  logic [CW-1:0]         cfg_data,
	input  logic [DATA_WIDTH-1:0] rd_data,
	output cell_cmd_t             cmd,
	output logic [CW-1:0]         cnt,
	output logic                  done,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [CW-1:0]         count,
	output logic                  is_full,
	output logic                  is_empty
);

	localparam int            CAP_RST_I = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
	localparam logic [CW-1:0] CAP_RST   = CW'(CAP_RST_I);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         cnt_nx;
	logic [CW-1:0]         pos_x;
	logic                  in_range;
	logic                  ins_ok, rem_ok, wr_ok, rd_ok;
	status_t               st;
	logic                  done_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic [CW-1:0]         count_q;
	logic                  is_full_q, is_empty_q;

	assign pos_x    = CW'(position);
	assign in_range = pos_x < cnt_q;

	always_comb begin
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		wr_ok  = 1'b0;
		rd_ok  = 1'b0;
		st     = ST_DONE;
		cnt_nx = cnt_q;
		case (kind_t'(kind))
			KIND_INSERT: begin
				// range is checked before fullness
				if (pos_x > cnt_q) begin
					st = ST_RANGE;
				end else if (cnt_q >= cap_q) begin
					st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
					cnt_nx = cnt_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else begin
					rem_ok = 1'b1;
					cnt_nx = cnt_q - CW'(1);
				end
			end
			KIND_OVERWRITE: begin
				if (!in_range) st = ST_RANGE;
				else wr_ok = 1'b1;
			end
			KIND_READ: begin
				if (!in_range) st = ST_RANGE;
				else rd_ok = 1'b1;
			end
			default: begin
				st = ST_RANGE;
			end
		endcase
	end

	assign cmd.ins = start && ins_ok;
	assign cmd.rem = start && rem_ok;
	assign cmd.wr  = start && wr_ok;
	assign cnt     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cap_q  <= CAP_RST;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) cnt_q <= cnt_nx;
			if (cfg_valid) begin
				if (cfg_data == '0) cap_q <= CW'(1);
				else if (cfg_data > DEPTH_C) cap_q <= DEPTH_C;
				else cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status_q     <= st;
			read_value_q <= rd_ok ? rd_data : '0;
			count_q      <= cnt_nx;
			is_full_q    <= cnt_nx >= cap_q;
			is_empty_q   <= cnt_nx == '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;
	assign is_full    = is_full_q;
	assign is_empty   = is_empty_q;

	`BOL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= DEPTH_C, "count above depth")
	`BOL_ASSERT_NXT(a_ins_grow, cmd.ins, cnt_q == $past(cnt_q) + CW'(1), "insert lost a count")
	`BOL_ASSERT_NXT(a_rem_shrink, cmd.rem, cnt_q == $past(cnt_q) - CW'(1), "remove lost a count")
	`BOL_ASSERT_IMP(a_bad_no_data, done_q && status_q != ST_DONE, read_value_q == '0, "data on failed request")
	`BOL_ASSERT_IMP(a_res_count, done_q, count_q == cnt_q, "result count differs from stored count")

endmodule

// File: hdl/bounded_ordered_list.sv
// An accepted request gives its result beat (done high) in the next cycle.
// Throughput: one request per cycle; busy stays low, the whole cell row shifts at once.
// Reset: arst_n clears the count, sets capacity to 16 (or DEPTH if smaller), drops done.
// Entries are not cleared; a slot is always written before the count covers it.
// The receiver cannot stall: each result is valid for the single cycle that done is high.
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of words with insert, remove, overwrite and read at an index,
// built as a row of shifting cells.
// ----------------------------------------------------------------------------
module bounded_ordered_list import bol_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic [$clog2(DEPTH)-1:0]     position,
	input  logic [DATA_WIDTH-1:0]        value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [$clog2(DEPTH+1)-1:0]   cfg_data,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [DATA_WIDTH-1:0]        read_value,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         is_full,
	output logic                         is_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cell_cmd_t             cmd;
	logic [CW-1:0]         cnt;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  go;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign go        = start && !busy;

	assign rd_data = cell_data[position];

	bol_ctrl #(
		.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .PW(PW), .CW(CW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(go), .kind(kind), .position(position),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_data(cfg_data), .rd_data(rd_data),
		.cmd(cmd), .cnt(cnt), .done(done), .status(status), .read_value(read_value),
		.count(count), .is_full(is_full), .is_empty(is_empty)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d, right_d;
		// end cells never take from outside the row
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		bol_cell #(
			.DATA_WIDTH(DATA_WIDTH), .PW(PW), .CW(CW), .INDEX(i)
		) u_cell (
			.clk(clk), .cmd(cmd), .pos(position), .cnt(cnt), .value(value),
			.left_data(left_d), .right_data(right_d), .data(cell_data[i])
		);
	end

endmodule

// File: dv/bol_list_checker.sv
// ----------------------------------------------------------------------------
// bol_list_checker
// Watches the request, capacity and result channels of the ordered list,
// keeps a shadow copy of the list, and checks every result beat in order.
// ----------------------------------------------------------------------------
module bol_list_checker import bol_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [3:0]  position,
	input  logic [31:0] value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] read_value,
	input  logic [4:0]  count,
	input  logic        is_full,
	input  logic        is_empty,
	output int          mismatch_count,
	output int          results_due,
	output int          results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     status;
		logic [31:0] rd;
		logic [4:0]  cnt;
		logic        full;
		logic        empty;
	} list_result_t;

	logic [31:0]  shadow_words [16];
	int           shadow_len;
	logic [4:0]   shadow_cap;
	list_result_t results_q [$];
	list_result_t want;

	// capacity register is clamped to 1..16 before use
	function automatic int usable_capacity();
		if (shadow_cap == 5'd0)
			return 1;
		if (shadow_cap > 5'd16)
			return 16;
		return int'(shadow_cap);
	endfunction

	function automatic list_result_t apply_request(kind_t k, logic [3:0] p, logic [31:0] v);
		list_result_t r;
		int lim;
		lim = usable_capacity();
		r.status = ST_DONE;
		r.rd = '0;
		if (k == KIND_INSERT) begin
			// position is checked before fullness
			if (int'(p) > shadow_len) begin
				r.status = ST_RANGE;
			end else if (shadow_len >= lim) begin
				r.status = ST_FULL;
			end else begin
				for (int i = shadow_len; i > int'(p); i--)
					shadow_words[i] = shadow_words[i-1];
				shadow_words[p] = v;
				shadow_len++;
			end
		end else if (int'(p) >= shadow_len) begin
			r.status = ST_RANGE;
		end else begin
			case (k)
				KIND_REMOVE: begin
					for (int i = int'(p); i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_len--;
				end
				KIND_OVERWRITE: shadow_words[p] = v;
				default: r.rd = shadow_words[p];
			endcase
		end
		r.cnt = shadow_len[4:0];
		r.full = (shadow_len >= lim);
		r.empty = (shadow_len == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			shadow_cap = 5'(CAP_RESET);
			results_q.delete();
			mismatch_count = 0;
			results_checked = 0;
		end else begin
			if (done) begin
				if (results_q.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatch_count++;
				end else begin
					want = results_q.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("read_value", want.rd, read_value);
					check_field("count", 32'(want.cnt), 32'(count));
					check_field("is_full", 32'(want.full), 32'(is_full));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_cap = cfg_data;
			if (start && !busy)
				results_q.push_back(apply_request(kind_t'(kind), position, value));
		end
		results_due = results_q.size();
	end

endmodule

// File: dv/tb_bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list
// Drives directed and random list requests through several capacity
// settings and sender gap rates; the checker scores every result beat.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list import bol_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = '0;
	logic [3:0]  position = '0;
	logic [31:0] value = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic [4:0]  count;
	logic        is_full;
	logic        is_empty;

	int          mismatch_count;
	int          results_due;
	int          results_checked;
	int          gap_pct = 0;
	int          requests_sent = 0;
	int          cap_writes = 0;
	bit          stuck = 1'b0;
	logic [4:0]  seen_len = '0;

	always #6 clk = ~clk;

	bounded_ordered_list u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .position(position), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .read_value(read_value), .count(count),
		.is_full(is_full), .is_empty(is_empty)
	);

	bol_list_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .position(position), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .read_value(read_value), .count(count),
		.is_full(is_full), .is_empty(is_empty),
		.mismatch_count(mismatch_count), .results_due(results_due),
		.results_checked(results_checked)
	);

	// list length as last reported, one beat behind; only steers positions
	always @(posedge clk)
		if (done)
			seen_len <= count;

	task automatic send_req(kind_t k, logic [3:0] p, logic [31:0] v);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		position <= p;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// stop sending, let every outstanding beat return, then settle
	task automatic drain();
		int waited;
		waited = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (results_due != 0 && waited < 200);
		if (results_due != 0) begin
			$error("%0d results still outstanding after drain", results_due);
			stuck = 1'b1;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] c);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int roll;
		int ins_w;
		int rem_w;
		int lim;
		kind_t k;
		logic [3:0] p;
		logic [31:0] v;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty list: every kind out of range, insert past the end too
		send_req(KIND_READ, 4'd0, 32'h0);
		send_req(KIND_REMOVE, 4'd0, 32'h0);
		send_req(KIND_OVERWRITE, 4'd0, 32'hDEADBEEF);
		send_req(KIND_INSERT, 4'd1, 32'h1);
		// build up: at end, at front, in the middle
		send_req(KIND_INSERT, 4'd0, 32'hFFFFFFFF);
		send_req(KIND_INSERT, 4'd1, 32'h0);
		send_req(KIND_INSERT, 4'd0, 32'hA5A5A5A5);
		send_req(KIND_INSERT, 4'd1, 32'h5A5A5A5A);
		send_req(KIND_INSERT, 4'd15, 32'h1);
		for (int i = 0; i < 4; i++)
			send_req(KIND_READ, 4'(i), 32'hFFFFFFFF);
		send_req(KIND_OVERWRITE, 4'd3, 32'h12345678);
		send_req(KIND_READ, 4'd3, 32'h0);
		send_req(KIND_READ, 4'd4, 32'h0);
		send_req(KIND_REMOVE, 4'd1, 32'h0);
		send_req(KIND_REMOVE, 4'd2, 32'h0);
		send_req(KIND_READ, 4'd0, 32'h0);
		send_req(KIND_READ, 4'd1, 32'h0);
		send_req(KIND_REMOVE, 4'd0, 32'h0);
		// small capacity: fill, refuse as full, range wins over full
		write_capacity(5'd2);
		send_req(KIND_INSERT, 4'd0, 32'h00000001);
		send_req(KIND_INSERT, 4'd2, 32'h2);
		send_req(KIND_INSERT, 4'd3, 32'h3);
		// capacity zero acts as one and drops below the current length
		write_capacity(5'd0);
		send_req(KIND_READ, 4'd1, 32'h0);
		send_req(KIND_REMOVE, 4'd1, 32'h0);
		send_req(KIND_OVERWRITE, 4'd0, 32'h80000000);
		send_req(KIND_INSERT, 4'd0, 32'h4);

		for (int ph = 0; ph < 8; ph++) begin
			gap_pct = (ph < 3) ? 11 : (ph < 6) ? 55 : 0;
			case (ph)
				0: write_capacity(5'd16);
				1: write_capacity(5'd3);
				2: write_capacity(5'd31);
				3: write_capacity(5'd0);
				4: write_capacity(5'd12);
				5: write_capacity(5'd1);
				6: write_capacity(5'd17);
				default: write_capacity(5'($urandom_range(31)));
			endcase
			for (int n = 0; n < 240; n++) begin
				// alternate fill and drain stretches so the length sweeps
				if ((n / 40) % 2 == 0) begin
					ins_w = 45;
					rem_w = 20;
				end else begin
					ins_w = 15;
					rem_w = 45;
				end
				roll = $urandom_range(99);
				if (roll < ins_w)
					k = KIND_INSERT;
				else if (roll < ins_w + rem_w)
					k = KIND_REMOVE;
				else if (roll < ins_w + rem_w + 20)
					k = KIND_OVERWRITE;
				else
					k = KIND_READ;
				if ($urandom_range(99) < 85) begin
					lim = (k == KIND_INSERT) ? int'(seen_len) : int'(seen_len) - 1;
					if (lim > 15)
						lim = 15;
					p = (lim < 0) ? 4'd0 : 4'($urandom_range(lim));
				end else begin
					p = 4'($urandom_range(15));
				end
				roll = $urandom_range(99);
				if (roll < 5)
					v = 32'h0;
				else if (roll < 10)
					v = 32'hFFFFFFFF;
				else
					v = $urandom();
				send_req(k, p, v);
			end
		end

		drain();
		$display("covered %0d requests, %0d result beats checked, %0d capacity writes",
			requests_sent, results_checked, cap_writes);
		$display("sender gaps at 11, 55 and 0 percent; capacities 0..31 incl. clamped values");
		if (mismatch_count == 0 && !stuck)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
